// ----- design/trb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_pkg: shared types and constants of the TCP flow reorder buffer
// Beat payloads, the held-entry layout, configuration and sequence helpers.
// ----------------------------------------------------------------------------
package trb_pkg;

   localparam logic [31:0] SEQ_MODULUS = 32'hFFFFFFFF;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] STREAK_MAX = 8'hFF;
   localparam logic [7:0] STREAK_THRESHOLD_RESET = 8'd8;
   localparam logic [3:0] SLIDE_FACTOR_RESET = 4'd2;

   // Register indexes (paddr bit 2).
   localparam logic REG_STREAK_THRESHOLD = 1'b0;
   localparam logic REG_SLIDE_FACTOR = 1'b1;

   typedef struct packed {
      logic [31:0] flow_key;
      logic [31:0] seq_num;
      logic [15:0] payload_len;
      logic        syn_flag;
      logic        fin_flag;
      logic [9:0]  seg_handle;
   } req_type;

   typedef struct packed {
      logic [9:0] out_handle;
      logic       last_out;
      logic       table_full;
   } rsp_type;

   // Held segment, 59 bits: handle, fin, length, sequence.
   typedef struct packed {
      logic [9:0]  handle;
      logic        fin;
      logic [15:0] length;
      logic [31:0] seq;
   } held_type;

   typedef struct packed {
      logic [31:0] flow_key;
      logic        syn_flag;
      held_type    entry;
   } queue_item_type;

   typedef struct packed {
      logic [7:0] streak_threshold;
      logic [3:0] slide_factor;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_DRAIN_RD,
      ST_DRAIN_EV,
      ST_FLUSH_RD,
      ST_FLUSH_CHK,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INS_PUT,
      ST_DUMP_RD,
      ST_DUMP_EV,
      ST_DUMP_END,
      ST_FINISH
   } state_type;

   // Sequence advance: wraps at 2^32, then reduced modulo all-ones.
   function automatic logic [31:0] wrap_add(logic [31:0] base, logic [31:0] add);
      logic [31:0] sum;
      sum = base + add;
      return (sum == SEQ_MODULUS) ? 32'd0 : sum;
   endfunction

   // End of a segment starting at from; a FIN takes one more sequence number.
   function automatic logic [31:0] seg_end(logic [31:0] from, held_type e);
      return wrap_add(from, 32'(e.length) + 32'(e.fin));
   endfunction

endpackage
`default_nettype wire

// ----- design/trb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_front: request intake
// Accepts segment beats, packs them into held-entry form and queues them.
// ----------------------------------------------------------------------------
module trb_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  trb_pkg::req_type        req_data,
   output logic                    q_valid,
   input  wire                     q_pop,
   output trb_pkg::queue_item_type q_item
);

   localparam int PTR_W = $clog2(trb_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(trb_pkg::QUEUE_DEPTH + 1);

   trb_pkg::queue_item_type q_ff [trb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   trb_pkg::queue_item_type item;
   logic push, pop;

   always_comb begin
      item.flow_key     = req_data.flow_key;
      item.syn_flag     = req_data.syn_flag;
      item.entry.handle = req_data.seg_handle;
      item.entry.fin    = req_data.fin_flag;
      item.entry.length = req_data.payload_len;
      item.entry.seq    = req_data.seq_num;
   end

   assign req_stall = (cnt_ff == CNT_W'(trb_pkg::QUEUE_DEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = q_ff[rd_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_in  = push ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

// ----- design/trb_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trb_engine: flow table and reorder sequencer
// Looks up the flow, then drains, inserts or flushes held segments one entry
// at a time through the hold memory and releases handles in order.
// ----------------------------------------------------------------------------
module trb_engine #(
   parameter int FLOW_SLOTS = 8,
   parameter int HOLD_DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  trb_pkg::cfg_type        cfg,
   input  wire                     q_valid,
   output logic                    q_pop,
   input  trb_pkg::queue_item_type q_item,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output trb_pkg::rsp_type        rsp_data
);

   localparam int SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
   localparam int MEM_DEPTH = FLOW_SLOTS * HOLD_DEPTH;
   localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // Per-flow table
   logic              used_ff [FLOW_SLOTS], used_in [FLOW_SLOTS];
   logic [31:0]       flow_ff [FLOW_SLOTS], flow_in [FLOW_SLOTS];
   logic [31:0]       exp_ff [FLOW_SLOTS], exp_in [FLOW_SLOTS];
   logic              ev_ff [FLOW_SLOTS], ev_in [FLOW_SLOTS];
   logic [CNT_W-1:0]  cnt_ff [FLOW_SLOTS], cnt_in [FLOW_SLOTS];
   logic [7:0]        streak_ff [FLOW_SLOTS], streak_in [FLOW_SLOTS];
   logic              closing_ff [FLOW_SLOTS], closing_in [FLOW_SLOTS];

   // Hold store
   trb_pkg::held_type mem [MEM_DEPTH];
   trb_pkg::held_type rdata_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   trb_pkg::held_type wr_data;

   // Sequencer
   trb_pkg::state_type      state_ff, state_in;
   trb_pkg::queue_item_type item_ff, item_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        idx_ff, idx_in, i_ff, i_in;
   logic                    flush_ff, flush_in;

   // Result path: one pending result, so the last one can be marked
   logic             pend_v_ff, pend_v_in;
   logic [9:0]       pend_hdl_ff, pend_hdl_in;
   logic             pend_tf_ff, pend_tf_in;
   logic             rsp_v_ff, rsp_v_in;
   trb_pkg::rsp_type rsp_ff, rsp_in;

   logic             emit, emit_tf, finish, can, out_free;
   logic [9:0]       emit_hdl;
   logic             found, has_free;
   logic [SLOT_W-1:0] match_slot, free_slot;
   logic [CNT_W-1:0] cur_cnt;
   logic [31:0]      cur_exp, sn;
   logic [7:0]       cur_streak;
   logic [19:0]      slide_amt;
   trb_pkg::held_type pk;

   function automatic logic [ADDR_W-1:0] haddr(logic [SLOT_W-1:0] sl, logic [CNT_W-1:0] ix);
      return ADDR_W'(int'(sl) * HOLD_DEPTH + int'(ix));
   endfunction

   assign out_free   = !rsp_v_ff || !rsp_stall;
   assign can        = !pend_v_ff || out_free;
   assign cur_cnt    = cnt_ff[slot_ff];
   assign cur_exp    = exp_ff[slot_ff];
   assign cur_streak = streak_ff[slot_ff];
   assign pk         = item_ff.entry;
   assign sn         = item_ff.entry.seq;
   assign slide_amt  = {4'b0, item_ff.entry.length} * {16'b0, cfg.slide_factor};
   assign rsp_valid  = rsp_v_ff;
   assign rsp_data   = rsp_ff;

   // Slot search: lowest matching used slot and lowest free slot.
   always_comb begin
      found      = 1'b0;
      has_free   = 1'b0;
      match_slot = '0;
      free_slot  = '0;
      for (int k = FLOW_SLOTS - 1; k >= 0; k--) begin
         if (used_ff[k] && flow_ff[k] == item_ff.flow_key) begin
            found      = 1'b1;
            match_slot = SLOT_W'(k);
         end
         if (!used_ff[k]) begin
            has_free  = 1'b1;
            free_slot = SLOT_W'(k);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      i_in       = i_ff;
      flush_in   = flush_ff;
      used_in    = used_ff;
      flow_in    = flow_ff;
      exp_in     = exp_ff;
      ev_in      = ev_ff;
      cnt_in     = cnt_ff;
      streak_in  = streak_ff;
      closing_in = closing_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = pk;
      emit       = 1'b0;
      emit_hdl   = pk.handle;
      emit_tf    = 1'b0;
      finish     = 1'b0;
      q_pop      = 1'b0;

      if (can) begin
         case (state_ff)
            trb_pkg::ST_IDLE: begin
               if (q_valid) begin
                  q_pop    = 1'b1;
                  item_in  = q_item;
                  state_in = trb_pkg::ST_LOOKUP;
               end
            end
            trb_pkg::ST_LOOKUP: begin
               if (found) begin
                  slot_in  = match_slot;
                  state_in = trb_pkg::ST_DECIDE;
               end else if (has_free) begin
                  slot_in               = free_slot;
                  used_in[free_slot]    = 1'b1;
                  flow_in[free_slot]    = item_ff.flow_key;
                  ev_in[free_slot]      = 1'b0;
                  cnt_in[free_slot]     = '0;
                  streak_in[free_slot]  = '0;
                  closing_in[free_slot] = 1'b0;
                  state_in              = trb_pkg::ST_DECIDE;
               end else begin
                  emit     = 1'b1;
                  emit_tf  = 1'b1;
                  state_in = trb_pkg::ST_FINISH;
               end
            end
            trb_pkg::ST_DECIDE: begin
               if (item_ff.syn_flag) begin
                  exp_in[slot_ff] = sn + 32'd1;
                  ev_in[slot_ff]  = 1'b1;
                  emit            = 1'b1;
                  state_in        = trb_pkg::ST_FINISH;
               end else if (closing_ff[slot_ff]) begin
                  used_in[slot_ff] = 1'b0;
                  emit             = 1'b1;
                  state_in         = trb_pkg::ST_FINISH;
               end else if (!ev_ff[slot_ff]) begin
                  emit     = 1'b1;
                  state_in = trb_pkg::ST_FINISH;
               end else if (sn <= cur_exp) begin
                  emit               = 1'b1;
                  streak_in[slot_ff] = '0;
                  if (sn == cur_exp) begin
                     exp_in[slot_ff] = trb_pkg::seg_end(cur_exp, pk);
                     if (pk.fin) begin
                        closing_in[slot_ff] = 1'b1;
                     end
                  end
                  state_in = trb_pkg::ST_DRAIN_RD;
               end else if (cur_cnt < CNT_W'(HOLD_DEPTH) && cur_streak < cfg.streak_threshold)
               begin
                  flush_in = 1'b0;
                  idx_in   = '0;
                  state_in = trb_pkg::ST_INS_RD;
               end else begin
                  flush_in = 1'b1;
                  state_in = trb_pkg::ST_FLUSH_RD;
               end
            end
            trb_pkg::ST_DRAIN_RD: begin
               if (cur_cnt == '0) begin
                  state_in = trb_pkg::ST_FINISH;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = haddr(slot_ff, cur_cnt - CNT_W'(1));
                  state_in = trb_pkg::ST_DRAIN_EV;
               end
            end
            trb_pkg::ST_DRAIN_EV: begin
               if (rdata_ff.seq > cur_exp) begin
                  state_in = trb_pkg::ST_FINISH;
               end else begin
                  emit     = 1'b1;
                  emit_hdl = rdata_ff.handle;
                  if (rdata_ff.seq == cur_exp) begin
                     exp_in[slot_ff] = trb_pkg::seg_end(cur_exp, rdata_ff);
                     if (rdata_ff.fin) begin
                        closing_in[slot_ff] = 1'b1;
                     end
                  end
                  cnt_in[slot_ff] = cur_cnt - CNT_W'(1);
                  state_in        = trb_pkg::ST_DRAIN_RD;
               end
            end
            trb_pkg::ST_FLUSH_RD: begin
               if (cur_cnt == '0) begin
                  emit     = 1'b1;
                  i_in     = '0;
                  state_in = trb_pkg::ST_DUMP_RD;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = haddr(slot_ff, cur_cnt - CNT_W'(1));
                  state_in = trb_pkg::ST_FLUSH_CHK;
               end
            end
            trb_pkg::ST_FLUSH_CHK: begin
               if (sn < rdata_ff.seq) begin
                  emit     = 1'b1;
                  i_in     = cur_cnt;
                  state_in = trb_pkg::ST_DUMP_RD;
               end else begin
                  emit            = 1'b1;
                  emit_hdl        = rdata_ff.handle;
                  cnt_in[slot_ff] = cur_cnt - CNT_W'(1);
                  idx_in          = '0;
                  state_in        = trb_pkg::ST_INS_RD;
               end
            end
            trb_pkg::ST_INS_RD: begin
               if (idx_ff < cur_cnt) begin
                  rd_en    = 1'b1;
                  rd_addr  = haddr(slot_ff, idx_ff);
                  state_in = trb_pkg::ST_INS_CMP;
               end else begin
                  i_in     = cur_cnt;
                  state_in = trb_pkg::ST_SHIFT_RD;
               end
            end
            trb_pkg::ST_INS_CMP: begin
               if (sn <= rdata_ff.seq) begin
                  if (sn == rdata_ff.seq) begin
                     exp_in[slot_ff] = trb_pkg::seg_end(sn, pk);
                     if (pk.fin) begin
                        closing_in[slot_ff] = 1'b1;
                     end
                  end
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = trb_pkg::ST_INS_RD;
               end else begin
                  i_in     = cur_cnt;
                  state_in = trb_pkg::ST_SHIFT_RD;
               end
            end
            trb_pkg::ST_SHIFT_RD: begin
               if (i_ff > idx_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = haddr(slot_ff, i_ff - CNT_W'(1));
                  state_in = trb_pkg::ST_SHIFT_WR;
               end else begin
                  state_in = trb_pkg::ST_INS_PUT;
               end
            end
            trb_pkg::ST_SHIFT_WR: begin
               wr_en    = 1'b1;
               wr_addr  = haddr(slot_ff, i_ff);
               wr_data  = rdata_ff;
               i_in     = i_ff - CNT_W'(1);
               state_in = trb_pkg::ST_SHIFT_RD;
            end
            trb_pkg::ST_INS_PUT: begin
               wr_en           = 1'b1;
               wr_addr         = haddr(slot_ff, idx_ff);
               wr_data         = pk;
               cnt_in[slot_ff] = cur_cnt + CNT_W'(1);
               if (cur_streak != trb_pkg::STREAK_MAX) begin
                  streak_in[slot_ff] = cur_streak + 8'd1;
               end
               if (flush_ff) begin
                  i_in     = cur_cnt + CNT_W'(1);
                  state_in = trb_pkg::ST_DUMP_RD;
               end else begin
                  state_in = trb_pkg::ST_FINISH;
               end
            end
            trb_pkg::ST_DUMP_RD: begin
               if (i_ff == '0) begin
                  state_in = trb_pkg::ST_DUMP_END;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = haddr(slot_ff, i_ff - CNT_W'(1));
                  state_in = trb_pkg::ST_DUMP_EV;
               end
            end
            trb_pkg::ST_DUMP_EV: begin
               emit     = 1'b1;
               emit_hdl = rdata_ff.handle;
               if (rdata_ff.fin) begin
                  closing_in[slot_ff] = 1'b1;
               end
               if (i_ff == CNT_W'(1)) begin
                  exp_in[slot_ff] = trb_pkg::seg_end(rdata_ff.seq, rdata_ff);
               end
               i_in     = i_ff - CNT_W'(1);
               state_in = trb_pkg::ST_DUMP_RD;
            end
            trb_pkg::ST_DUMP_END: begin
               cnt_in[slot_ff] = '0;
               if (cur_streak >= cfg.streak_threshold) begin
                  exp_in[slot_ff] = trb_pkg::wrap_add(cur_exp, 32'(slide_amt));
               end
               state_in = trb_pkg::ST_FINISH;
            end
            trb_pkg::ST_FINISH: begin
               finish   = 1'b1;
               state_in = trb_pkg::ST_IDLE;
            end
            default: begin
               state_in = trb_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // A new result pushes the pending one out unmarked; the end marks it last.
   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_hdl_in = pend_hdl_ff;
      pend_tf_in  = pend_tf_ff;
      rsp_v_in    = rsp_v_ff && rsp_stall;
      rsp_in      = rsp_ff;
      if ((emit || finish) && pend_v_ff) begin
         rsp_v_in          = 1'b1;
         rsp_in.out_handle = pend_hdl_ff;
         rsp_in.last_out   = finish;
         rsp_in.table_full = pend_tf_ff;
      end
      if (emit) begin
         pend_v_in   = 1'b1;
         pend_hdl_in = emit_hdl;
         pend_tf_in  = emit_tf;
      end else if (finish) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= trb_pkg::ST_IDLE;
         slot_ff   <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         for (int k = 0; k < FLOW_SLOTS; k++) begin
            used_ff[k]    <= 1'b0;
            ev_ff[k]      <= 1'b0;
            cnt_ff[k]     <= '0;
            streak_ff[k]  <= '0;
            closing_ff[k] <= 1'b0;
         end
      end else begin
         state_ff   <= state_in;
         slot_ff    <= slot_in;
         pend_v_ff  <= pend_v_in;
         rsp_v_ff   <= rsp_v_in;
         used_ff    <= used_in;
         ev_ff      <= ev_in;
         cnt_ff     <= cnt_in;
         streak_ff  <= streak_in;
         closing_ff <= closing_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      i_ff        <= i_in;
      flush_ff    <= flush_in;
      flow_ff     <= flow_in;
      exp_ff      <= exp_in;
      pend_hdl_ff <= pend_hdl_in;
      pend_tf_ff  <= pend_tf_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

`ifndef ASSERT_OFF
   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[slot_ff] <= CNT_W'(HOLD_DEPTH))
      else $error("held count of the active flow beyond the hold depth");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == trb_pkg::ST_IDLE |-> !pend_v_ff)
      else $error("a result is still pending between segments");

   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.table_full |-> rsp_ff.last_out)
      else $error("table-full release not marked last");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == trb_pkg::ST_LOOKUP)
      else $error("queue popped without starting a lookup");
`endif

endmodule
`default_nettype wire

// ----- design/tcp_flow_reorder_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_flow_reorder_buffer: per-flow TCP segment reordering
// Releases segment handles of each flow in sequence order.
// ----------------------------------------------------------------------------
// Usage. The req_ channel carries one segment descriptor per beat; a beat is
// taken when req_valid is high and req_stall low. A two-beat queue sits in
// front, so descriptors are taken while the sequencer is busy. Each segment
// yields zero or more rsp_ beats (released handles), the final one with
// last_out set; a segment that is merely held yields none. table_full marks
// the lone pass-through of a segment whose flow found no free slot.
// Steps: a segment passes lookup and decision, then works through the
// hold-memory entries it touches (drain, insertion scan, shift and flush
// each read one entry per step over the single-read hold memory). While
// rsp_stall is high the sequencer holds its state once a result waits. Reset
// clears the flow table, empties the queue and restores streak_threshold to 8
// and slide_factor to 2. The csr_ port is written while no segment is in
// flight: address 0 is streak_threshold, address 4 slide_factor.
// ----------------------------------------------------------------------------
module tcp_flow_reorder_buffer #(
   parameter int FLOW_SLOTS = 8,
   parameter int HOLD_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  trb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output trb_pkg::rsp_type  rsp_data,
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire [2:0]         csr_paddr,
   input  wire [31:0]        csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   trb_pkg::cfg_type        cfg_ff, cfg_in;
   logic                    q_valid, q_pop;
   trb_pkg::queue_item_type q_item;

   // Registers are decoded on address bit 2; the byte lanes below are ignored.
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == trb_pkg::REG_STREAK_THRESHOLD) begin
            cfg_in.streak_threshold = csr_pwdata[7:0];
         end else begin
            cfg_in.slide_factor = csr_pwdata[3:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == trb_pkg::REG_SLIDE_FACTOR) begin
         csr_prdata = {28'b0, cfg_ff.slide_factor};
      end else begin
         csr_prdata = {24'b0, cfg_ff.streak_threshold};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.streak_threshold <= trb_pkg::STREAK_THRESHOLD_RESET;
         cfg_ff.slide_factor     <= trb_pkg::SLIDE_FACTOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: intake and queue.
   trb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   // Back: flow table, hold memory and release sequencing.
   trb_engine #(
      .FLOW_SLOTS (FLOW_SLOTS),
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- tb/sv/tb_tcp_flow_reorder_buffer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tcp_flow_reorder_buffer: self-checking bench for the flow reorder buffer
// Segment descriptors are sent through the req_ channel, each accepted beat
// updates a behavioural copy of the flow table, and the handles it predicts
// are compared field by field with the rsp_ beats. Several register settings
// are exercised, with random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb_tcp_flow_reorder_buffer;

   localparam int SLOTS = 8;
   localparam int DEPTH = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD = 400;
   localparam int NUM_KEYS = 10;

   // Behavioural copy of the reorder logic. Every accepted segment is turned
   // into the list of handles it releases, queued in release order.
   class reorder_predictor;
      logic [7:0]  threshold;
      logic [3:0]  slide;
      bit          used[SLOTS];
      logic [31:0] flow[SLOTS];
      logic [31:0] next_seq[SLOTS];
      bit          armed[SLOTS];
      int          held_cnt[SLOTS];
      int          streak[SLOTS];
      bit          closing[SLOTS];
      trb_pkg::held_type held[SLOTS][DEPTH];
      trb_pkg::rsp_type  pending_releases[$];
      int          released;
      int          table_full_seen;
      int          flushes;

      function new();
         threshold = trb_pkg::STREAK_THRESHOLD_RESET;
         slide = trb_pkg::SLIDE_FACTOR_RESET;
         for (int s = 0; s < SLOTS; s++) begin
            used[s] = 0; armed[s] = 0; held_cnt[s] = 0;
            streak[s] = 0; closing[s] = 0; flow[s] = '0; next_seq[s] = '0;
         end
         released = 0; table_full_seen = 0; flushes = 0;
      endfunction

      // Sequence advance: wraps at 2^32, and the all-ones value folds to zero.
      function logic [31:0] advance(logic [31:0] a, logic [31:0] b);
         logic [31:0] sum;
         sum = a + b;
         return (sum == 32'hFFFF_FFFF) ? 32'd0 : sum;
      endfunction

      function logic [31:0] end_of(int s, logic [31:0] from, trb_pkg::held_type e);
         if (e.fin) begin
            closing[s] = 1;
            return advance(from, {16'd0, e.length} + 32'd1);
         end
         return advance(from, {16'd0, e.length});
      endfunction

      function void release_handle(logic [9:0] h);
         trb_pkg::rsp_type r;
         r.out_handle = h;
         r.last_out = 1'b0;
         r.table_full = 1'b0;
         pending_releases.push_back(r);
      endfunction

      function void hold_segment(int s, trb_pkg::held_type e);
         int cnt;
         int idx;
         logic [31:0] sb;
         cnt = held_cnt[s];
         idx = 0;
         if (cnt >= DEPTH) return;
         if (cnt > 0) begin
            sb = held[s][0].seq;
            while (e.seq <= sb && idx < cnt) begin
               idx++;
               // A duplicate of a held sequence moves the expectation on.
               if (e.seq == sb) next_seq[s] = end_of(s, e.seq, e);
               if (idx < cnt) sb = held[s][idx].seq;
            end
            for (int i = cnt; i > idx; i--) held[s][i] = held[s][i - 1];
         end
         held[s][idx] = e;
         held_cnt[s] = cnt + 1;
         if (streak[s] < 255) streak[s]++;
      endfunction

      // Expected sequence of an armed flow, used to steer the stimulus.
      function bit peek_next(logic [31:0] key, output logic [31:0] nxt);
         nxt = '0;
         for (int s = 0; s < SLOTS; s++)
            if (used[s] && flow[s] == key && armed[s]) begin
               nxt = next_seq[s];
               return 1;
            end
         return 0;
      endfunction

      function void note_segment(trb_pkg::req_type q);
         trb_pkg::held_type pk;
         trb_pkg::held_type e;
         int s;
         int prior_size;
         bit found;
         trb_pkg::rsp_type r;
         logic [31:0] fin_end;
         pk.seq = q.seq_num;
         pk.length = q.payload_len;
         pk.fin = q.fin_flag;
         pk.handle = q.seg_handle;
         prior_size = pending_releases.size();
         found = 0;
         s = 0;
         for (int k = 0; k < SLOTS; k++)
            if (!found && used[k] && flow[k] == q.flow_key) begin
               found = 1; s = k;
            end
         if (!found) begin
            s = SLOTS;
            for (int k = SLOTS - 1; k >= 0; k--) if (!used[k]) s = k;
            if (s >= SLOTS) begin
               r.out_handle = q.seg_handle; r.last_out = 1'b1; r.table_full = 1'b1;
               pending_releases.push_back(r);
               table_full_seen++;
               return;
            end
            used[s] = 1; flow[s] = q.flow_key; armed[s] = 0;
            held_cnt[s] = 0; streak[s] = 0; closing[s] = 0;
         end

         if (q.syn_flag) begin
            next_seq[s] = q.seq_num + 32'd1;
            armed[s] = 1;
            release_handle(q.seg_handle);
         end else if (closing[s]) begin
            used[s] = 0;
            release_handle(q.seg_handle);
         end else if (!armed[s]) begin
            release_handle(q.seg_handle);
         end else if (q.seq_num <= next_seq[s]) begin
            release_handle(q.seg_handle);
            streak[s] = 0;
            if (q.seq_num == next_seq[s]) next_seq[s] = end_of(s, next_seq[s], pk);
            while (held_cnt[s] > 0) begin
               e = held[s][held_cnt[s] - 1];
               if (e.seq > next_seq[s]) break;
               release_handle(e.handle);
               if (e.seq == next_seq[s]) next_seq[s] = end_of(s, next_seq[s], e);
               held_cnt[s]--;
            end
         end else if (held_cnt[s] < DEPTH && streak[s] < threshold) begin
            hold_segment(s, pk);
         end else begin
            flushes++;
            if (held_cnt[s] == 0 || q.seq_num < held[s][held_cnt[s] - 1].seq) begin
               release_handle(q.seg_handle);
            end else begin
               release_handle(held[s][held_cnt[s] - 1].handle);
               held_cnt[s]--;
               hold_segment(s, pk);
            end
            for (int i = held_cnt[s]; i > 0; i--) begin
               e = held[s][i - 1];
               fin_end = end_of(s, e.seq, e);
               release_handle(e.handle);
               if (i == 1) next_seq[s] = fin_end;
            end
            held_cnt[s] = 0;
            // Apparent loss: slide the expectation past the missing data.
            if (streak[s] >= threshold)
               next_seq[s] = advance(next_seq[s], {16'd0, q.payload_len} * {28'd0, slide});
         end
         if (pending_releases.size() > prior_size)
            pending_releases[pending_releases.size() - 1].last_out = 1'b1;
      endfunction

      function bit check_release(trb_pkg::rsp_type got, output string msg);
         trb_pkg::rsp_type want;
         msg = "";
         if (pending_releases.size() == 0) begin
            $sformat(msg, "unexpected release: handle %0d last %0b full %0b",
                     got.out_handle, got.last_out, got.table_full);
            return 0;
         end
         want = pending_releases.pop_front();
         released++;
         if (got.out_handle !== want.out_handle)
            $sformat(msg, "out_handle %0d, expected %0d", got.out_handle, want.out_handle);
         else if (got.last_out !== want.last_out)
            $sformat(msg, "last_out %0b, expected %0b (handle %0d)",
                     got.last_out, want.last_out, want.out_handle);
         else if (got.table_full !== want.table_full)
            $sformat(msg, "table_full %0b, expected %0b (handle %0d)",
                     got.table_full, want.table_full, want.out_handle);
         return msg == "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   trb_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   trb_pkg::rsp_type rsp_data;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   reorder_predictor model = new();
   int  error_count = 0;
   int  segments_in = 0;
   int  idle_cycles = 0;
   bit  beat_seen = 0;
   bit  quiet = 0;
   bit  hold_now = 0;
   logic [31:0] key_pool[NUM_KEYS];

   tcp_flow_reorder_buffer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   task automatic report(string msg);
      error_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // A release predicted but never seen is a failure of its own.
   task automatic report_leftover();
      trb_pkg::rsp_type lost;
      lost = model.pending_releases.pop_front();
      report($sformatf("release of handle %0d never arrived", lost.out_handle));
   endtask

   // Both channels are sampled at the falling edge: stall and valid only move
   // at the rising edge, so what is seen here is what the next edge takes.
   always @(negedge clock) begin
      string msg;
      beat_seen = 0;
      if (!reset && req_valid && !req_stall) begin
         model.note_segment(req_data);
         segments_in++;
         beat_seen = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         beat_seen = 1;
         if (!model.check_release(rsp_data, msg)) report(msg);
      end
   end

   // Watchdog: too long without a single beat on either channel.
   always @(posedge clock) begin
      if (reset || beat_seen) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold-off on request, and
   // no stalling at all once the run is in its quiet tail.
   initial begin
      @(negedge reset);
      forever begin
         if (hold_now) begin
            hold_now = 0;
            rsp_stall <= 1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic csr_write(logic reg_index, logic [31:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {reg_index, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (reg_index == trb_pkg::REG_STREAK_THRESHOLD) model.threshold = value[7:0];
      else model.slide = value[3:0];
      @(posedge clock);
   endtask

   // Registers only change once every predicted release has come back and
   // any merely held segment has had time to leave the sequencer.
   task automatic wait_settled();
      while (model.pending_releases.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_segment(trb_pkg::req_type seg);
      bit taken;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= seg;
      do begin
         @(negedge clock);
         taken = req_valid && !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic trb_pkg::req_type make_seg(logic [31:0] key, logic [31:0] seq,
                                                 logic [15:0] len, bit syn, bit fin,
                                                 logic [9:0] hdl);
      trb_pkg::req_type r;
      r.flow_key = key; r.seq_num = seq; r.payload_len = len;
      r.syn_flag = syn; r.fin_flag = fin; r.seg_handle = hdl;
      return r;
   endfunction

   // Mostly well-formed traffic on a small set of flows, steered by the
   // expected sequence of each flow so that the holding, draining and
   // flushing paths are reached; a tenth of the beats is noise.
   function automatic trb_pkg::req_type random_seg();
      logic [31:0] key;
      logic [31:0] nxt;
      logic [15:0] len;
      logic [31:0] seq;
      bit          syn;
      bit          fin;
      int          pick;
      key = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, NUM_KEYS - 1)];
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1500));
      fin = ($urandom_range(0, 29) == 0);
      syn = 0;
      pick = $urandom_range(0, 99);
      if (!model.peek_next(key, nxt) || pick < 6) begin
         syn = ($urandom_range(0, 4) != 0);
         seq = $urandom();
      end else if (pick < 50) begin
         seq = nxt;
      end else if (pick < 80) begin
         seq = nxt + {16'd0, len} * $urandom_range(1, 4) + 32'd1;
      end else if (pick < 90) begin
         seq = nxt - $urandom_range(0, 100);
      end else begin
         seq = $urandom();
         syn = 1'($urandom_range(0, 1));
      end
      return make_seg(key, seq, len, syn, fin, 10'($urandom_range(0, 1023)));
   endfunction

   initial begin
      trb_pkg::req_type directed[$];
      logic [7:0] thr_set[4];
      logic [3:0] slide_set[4];
      int per_phase;

      thr_set = '{8'd8, 8'd1, 8'd255, 8'd3};
      slide_set = '{4'd2, 4'd0, 4'd15, 4'd1};
      per_phase = 62;
      for (int k = 0; k < NUM_KEYS; k++) key_pool[k] = 32'hA5C0_0000 + k * 32'h0001_1111;

      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed opening: sequence wrap, holding, duplicate with FIN,
      // closing, unarmed flows, extreme field values and a full flow table.
      directed.push_back(make_seg(32'h0, 32'hFFFF_FFF0, 16'd0, 1, 0, 10'd1));
      directed.push_back(make_seg(32'h0, 32'hFFFF_FFF1, 16'd14, 0, 0, 10'd2));
      directed.push_back(make_seg(32'h0, 32'd100, 16'd10, 0, 0, 10'd3));
      directed.push_back(make_seg(32'h0, 32'd50, 16'd10, 0, 0, 10'd4));
      directed.push_back(make_seg(32'h0, 32'd50, 16'd0, 0, 1, 10'd5));
      directed.push_back(make_seg(32'h0, 32'd0, 16'd0, 0, 0, 10'd6));
      directed.push_back(make_seg(32'hFFFF_FFFF, 32'd5, 16'd7, 0, 0, 10'd0));
      directed.push_back(make_seg(32'hFFFF_FFFF, 32'd0, 16'd0, 1, 0, 10'd1023));
      directed.push_back(make_seg(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 0, 0, 10'd512));
      directed.push_back(make_seg(32'hFFFF_FFFF, 32'h2_0000, 16'd1, 0, 0, 10'd9));
      directed.push_back(make_seg(32'hFFFF_FFFF, 32'd0, 16'd3, 0, 0, 10'd10));
      for (int k = 1; k <= 8; k++)
         directed.push_back(make_seg(32'h5555_0000 + k, 32'hFFFF_FFFF, 16'd1, 0, 0,
                                     10'(20 + k)));

      for (int p = 0; p < 4; p++) begin
         csr_write(trb_pkg::REG_STREAK_THRESHOLD, {24'd0, thr_set[p]});
         csr_write(trb_pkg::REG_SLIDE_FACTOR, {28'd0, slide_set[p]});
         if (p == 0)
            foreach (directed[i]) send_segment(directed[i]);
         for (int i = 0; i < per_phase; i++) begin
            if (p == 1 && i == 10) hold_now = 1;
            if (p == 3 && i == per_phase - 40) quiet = 1;
            send_segment(random_seg());
         end
         req_valid <= 0;
         // Free the table between phases so new flows can be taken again.
         wait_settled();
         if (p < 3) begin
            for (int s = 0; s < SLOTS; s++)
               if (model.used[s]) begin
                  send_segment(make_seg(model.flow[s], 32'd0, 16'd0, 0, 1, 10'd0));
                  send_segment(make_seg(model.flow[s], 32'd0, 16'd0, 0, 0, 10'd0));
               end
            req_valid <= 0;
            wait_settled();
         end
      end

      while (model.pending_releases.size() != 0) report_leftover();
      $display("Covered %0d segments, %0d released handles, %0d table-full passes,",
               segments_in, model.released, model.table_full_seen);
      $display("%0d flushes, over four threshold and slide settings.", model.flushes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
